// ----- hdl/button_press_series_decoder_defines.svh -----
// Assertion macros shared by the checker of the button press series decoder.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BUTTON_PRESS_SERIES_DECODER_DEFINES_SVH
`define BUTTON_PRESS_SERIES_DECODER_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define BPSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a signal holds while its channel is stalled
`define BPSD_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> $stable(sig)) \
    else $error(msg);

`endif

// ----- hdl/bpsd_pkg.sv -----
`timescale 1ns / 1ps
// Types and constants of the button press series decoder.
// No dependencies; used by the top level and its checker.
package bpsd_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_TICKS_PER_SECOND = 2'd0,
    REG_PRESS_THRESHOLD  = 2'd1,
    REG_ALLOW_UNLOCK     = 2'd2
  } cfg_reg_e;

  localparam int unsigned CfgAddrW   = 2;
  localparam int unsigned CfgDataW   = 12;
  localparam int unsigned TicksW     = 10;
  localparam int unsigned ThreshW    = 12;
  localparam int unsigned HalfW      = TicksW - 1;
  localparam int unsigned FiveW      = 13;
  localparam int unsigned TimerW     = 16;
  localparam int unsigned CountW     = 8;
  localparam int unsigned CodeW      = 16;
  localparam int unsigned NumDigits  = 4;
  localparam int unsigned OutFieldsW = 2 + CodeW;
  localparam int unsigned OutTdataW  = ((OutFieldsW + 7) / 8) * 8;

  // Reset values of the configuration and its derived limits
  localparam logic [TicksW-1:0]  TicksReset  = 10'd100;
  localparam logic [ThreshW-1:0] ThreshReset = 12'd1000;
  localparam logic [HalfW-1:0]   HalfReset   = 9'd50;
  localparam logic [FiveW-1:0]   FiveReset   = 13'd500;
  localparam logic [TimerW-1:0]  LimitReset  = 16'd6000;

  localparam logic [CountW-1:0]  SeriesFull  = 8'(NumDigits);

  typedef logic [CountW-1:0] digit_t;

endpackage

// ----- hdl/button_press_series_decoder.sv -----
`timescale 1ns / 1ps
// Top level of the button press series decoder: press detection, timers,
// digit store and code latch. Depends on bpsd_pkg.
//
// One sample (tick) is taken per clock cycle while the output is not stalled,
// and its result is registered: the sample waits in the input register until
// the result register can take it, and the whole state update is done by the
// logic between the input register and the result register. The result
// register lets the next sample enter while a result still waits on the
// output. The half-second, five-second and sixty-second limits are worked
// out when ticks_per_second is written, so configuration must be written
// while no sample is in flight. There is no clearing pass after reset; the
// block is ready at once.
module button_press_series_decoder
  import bpsd_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [CfgAddrW-1:0]                  cfg_addr_i,
  input  logic [CfgDataW-1:0]                  cfg_data_i,
  // Sample stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // fields from bit 0: sample
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  // Result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // fields from bit 0: pressed, long_press, digit_code
  output logic [OutTdataW-1:0]                 m_axis_tdata
);

  localparam int unsigned CmpW = (SAMPLE_WIDTH > ThreshW) ? SAMPLE_WIDTH : ThreshW;

  // Configuration and derived limits
  logic [ThreshW-1:0] thresh_q;
  logic               allow_q;
  logic [HalfW-1:0]   half_q;
  logic [FiveW-1:0]   five_q;
  logic [TimerW-1:0]  limit_q;

  // Pipeline registers
  logic                    in_valid_q;
  logic [SAMPLE_WIDTH-1:0] sample_q;
  logic                    out_valid_q;
  logic [OutTdataW-1:0]    out_data_q;

  // Decoder state
  logic               prev_q,   prev_d;
  logic [TimerW-1:0]  rel_q,    rel_d;
  logic [TimerW-1:0]  prt_q,    prt_d;
  digit_t             cnt_q,    cnt_d;
  digit_t             store_q [NumDigits];
  digit_t             store_d [NumDigits];
  digit_t             ser_q,    ser_d;
  logic [CodeW-1:0]   code_q,   code_d;

  logic pressed;
  logic long_press;
  logic advance;
  logic fire;

  assign cfg_ready_o   = 1'b1;
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Write configuration registers and precompute the timer limits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
      allow_q  <= 1'b0;
      half_q   <= HalfReset;
      five_q   <= FiveReset;
      limit_q  <= LimitReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_TICKS_PER_SECOND: begin
          half_q  <= cfg_data_i[TicksW-1:1];
          five_q  <= FiveW'(cfg_data_i[TicksW-1:0]) * FiveW'(5);
          limit_q <= TimerW'(cfg_data_i[TicksW-1:0]) * TimerW'(60);
        end
        REG_PRESS_THRESHOLD: thresh_q <= cfg_data_i[ThreshW-1:0];
        REG_ALLOW_UNLOCK:    allow_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Compute the next state for the sample in the input register
  always_comb begin
    logic [CodeW-1:0] code_new;
    pressed  = CmpW'(sample_q) < CmpW'(thresh_q);
    prev_d   = pressed;
    rel_d    = rel_q;
    prt_d    = prt_q;
    cnt_d    = cnt_q;
    ser_d    = ser_q;
    code_d   = code_q;
    store_d  = store_q;
    code_new = '0;
    if (pressed) begin
      if (!prev_q) begin
        rel_d = '0;
        prt_d = '0;
        cnt_d = cnt_q + 1'b1;
      end
      if (prt_d < limit_q) begin
        prt_d = prt_d + 1'b1;
      end
    end else begin
      if (rel_q < limit_q) begin
        rel_d = rel_q + 1'b1;
      end
      // Half a second released: shift the press count into the store
      if (rel_d == TimerW'(half_q)) begin
        for (int k = 0; k < NumDigits - 1; k++) begin
          store_d[k] = store_q[k+1];
        end
        store_d[NumDigits-1] = cnt_q;
        for (int k = 0; k < NumDigits; k++) begin
          code_new = CodeW'(code_new * CodeW'(10)) + CodeW'(store_d[k]);
        end
        ser_d = ser_q + 1'b1;
        if (ser_d == SeriesFull) begin
          code_d = code_new;
        end
        cnt_d = '0;
      end
      // Five seconds released: drop the series
      if (rel_d == TimerW'(five_q)) begin
        for (int k = 0; k < NumDigits; k++) begin
          store_d[k] = '0;
        end
        ser_d  = '0;
        code_d = '0;
        prt_d  = '0;
      end
    end
    long_press = allow_q && (prt_d > TimerW'(half_q));
  end

  // Hold the input register until the result register can take it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      sample_q <= s_axis_tdata[SAMPLE_WIDTH-1:0];
    end
  end

  // Advance the state and load the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      prev_q      <= 1'b0;
      rel_q       <= '0;
      prt_q       <= '0;
      cnt_q       <= '0;
      ser_q       <= '0;
      code_q      <= '0;
      for (int k = 0; k < NumDigits; k++) begin
        store_q[k] <= '0;
      end
    end else begin
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        prev_q  <= prev_d;
        rel_q   <= rel_d;
        prt_q   <= prt_d;
        cnt_q   <= cnt_d;
        ser_q   <= ser_d;
        code_q  <= code_d;
        store_q <= store_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= OutTdataW'({code_d, long_press, pressed});
    end
  end

endmodule

// ----- hdl/bpsd_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker of the button press series decoder, bound to the top.
// Depends on bpsd_pkg and button_press_series_decoder_defines.svh.
`include "button_press_series_decoder_defines.svh"

module bpsd_checker
  import bpsd_pkg::*;
(
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  // fields from bit 0: pressed, long_press, digit_code
  input logic [OutTdataW-1:0]              m_axis_tdata
);

  logic in_xact;
  logic out_stall;
  assign in_xact   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // Hold a stalled result
  `BPSD_ASSERT_HOLD(a_vld_hold, m_axis_tvalid, m_axis_tready, m_axis_tvalid, "valid dropped")
  `BPSD_ASSERT_HOLD(a_data_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata, "data changed")

  // A fresh result must come from an earlier sample transaction
  `BPSD_ASSERT(a_latency, $rose(m_axis_tvalid) |-> $past(in_xact, 2), "result without sample")

  // Back-pressure on the input only when the output is stalled
  `BPSD_ASSERT(a_input_stall, !s_axis_tready |-> out_stall, "input stalled alone")

endmodule

bind button_press_series_decoder bpsd_checker u_bpsd_checker (.*);

// ----- tb/tb_button_press_series_decoder.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the button press series decoder: random stream
// stalls on both sides, a tick-by-tick predictor and an in-order result check.
// Depends on bpsd_pkg and the button_press_series_decoder top level.
module tb_button_press_series_decoder;
  import bpsd_pkg::*;

  localparam int unsigned SampleW     = 12;
  localparam int unsigned InTdataW    = ((SampleW + 7) / 8) * 8;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 8;
  // above this rate a full series takes too long, so use plain level bursts
  localparam int unsigned SlowTicks   = 40;
  localparam logic [CfgAddrW-1:0] CfgAddrSpare = 2'd3;

  // One result of the block, pressed in the lowest bit
  typedef struct packed {
    logic [CodeW-1:0] digit_code;
    logic             long_press;
    logic             pressed;
  } tick_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgAddrW-1:0]  cfg_addr_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  // Predictor configuration and state, reset values at start
  logic [TicksW-1:0]  tps_q = TicksReset;
  logic [ThreshW-1:0] thr_q = ThreshReset;
  logic               unlock_q = 1'b0;
  logic               prev_pressed_q = 1'b0;
  logic [TimerW-1:0]  release_ticks_q = '0;
  logic [TimerW-1:0]  press_ticks_q = '0;
  logic [CountW-1:0]  press_count_q = '0;
  logic [CountW-1:0]  series_count_q = '0;
  logic [CodeW-1:0]   code_q = '0;
  digit_t             digits_q [NumDigits] = '{default: '0};

  logic [SampleW-1:0] pending_samples [$];
  tick_result_t       expected_ticks [$];
  int                 pushed_count = 0;
  int                 cfg_writes = 0;
  int                 fail_count = 0;
  int                 stall_cycles = 0;
  int                 in_gap = 0;
  int                 out_stall = 0;
  logic               in_fire = 1'b0;
  logic               calm = 1'b0;

  button_press_series_decoder #(
    .SAMPLE_WIDTH(SampleW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Advance the decoder state by one tick and return what it shows
  function automatic tick_result_t predict_tick(logic [SampleW-1:0] smp);
    logic [31:0]      half;
    logic [31:0]      five;
    logic [31:0]      limit;
    logic [CodeW-1:0] code;
    logic             now_pressed;
    tick_result_t     res;
    int               k;
    half  = 32'(tps_q) / 32'd2;
    five  = 32'(tps_q) * 32'd5;
    limit = 32'(tps_q) * 32'd60;
    now_pressed = (smp < thr_q);
    if (now_pressed) begin
      // press edge restarts both timers and counts the press
      if (!prev_pressed_q) begin
        release_ticks_q = '0;
        press_ticks_q   = '0;
        press_count_q   = press_count_q + 1'b1;
      end
      if (32'(press_ticks_q) < limit) press_ticks_q = press_ticks_q + 1'b1;
    end else begin
      if (32'(release_ticks_q) < limit) release_ticks_q = release_ticks_q + 1'b1;
      // half a second of release closes a digit
      if (32'(release_ticks_q) == half) begin
        for (k = 0; k < NumDigits - 1; k++) digits_q[k] = digits_q[k + 1];
        digits_q[NumDigits - 1] = press_count_q;
        code = '0;
        for (k = 0; k < NumDigits; k++) code = code * 16'd10 + CodeW'(digits_q[k]);
        series_count_q = series_count_q + 1'b1;
        if (series_count_q == SeriesFull) code_q = code;
        press_count_q = '0;
      end
      // five seconds of release wipes the series
      if (32'(release_ticks_q) == five) begin
        for (k = 0; k < NumDigits; k++) digits_q[k] = '0;
        series_count_q = '0;
        code_q         = '0;
        press_ticks_q  = '0;
      end
    end
    prev_pressed_q = now_pressed;
    res.pressed    = now_pressed;
    res.long_press = unlock_q && (32'(press_ticks_q) > half);
    res.digit_code = code_q;
    return res;
  endfunction

  // Sample edge: track configuration, predict inputs, check results
  always @(posedge clk_i) begin
    tick_result_t want;
    tick_result_t got;
    logic         cfg_fire;
    logic         out_fire;
    cfg_fire = cfg_valid_i && cfg_ready_o;
    out_fire = m_axis_tvalid && m_axis_tready;
    in_fire  = s_axis_tvalid && s_axis_tready;
    if (cfg_fire) begin
      case (cfg_addr_i)
        REG_TICKS_PER_SECOND: tps_q    = cfg_data_i[TicksW-1:0];
        REG_PRESS_THRESHOLD:  thr_q    = cfg_data_i[ThreshW-1:0];
        REG_ALLOW_UNLOCK:     unlock_q = cfg_data_i[0];
        default: ;
      endcase
      cfg_writes++;
    end
    if (in_fire) begin
      expected_ticks.push_back(predict_tick(s_axis_tdata[SampleW-1:0]));
      void'(pending_samples.pop_front());
    end
    if (out_fire) begin
      got = m_axis_tdata[$bits(tick_result_t)-1:0];
      if (expected_ticks.size() == 0) begin
        $error("unexpected result transaction, tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_ticks.pop_front();
        if (got.pressed !== want.pressed) begin
          $error("pressed: expected %0d, actual %0d", want.pressed, got.pressed);
          fail_count++;
        end
        if (got.long_press !== want.long_press) begin
          $error("long_press: expected %0d, actual %0d", want.long_press, got.long_press);
          fail_count++;
        end
        if (got.digit_code !== want.digit_code) begin
          $error("digit_code: expected %0d, actual %0d", want.digit_code, got.digit_code);
          fail_count++;
        end
      end
    end
    if (cfg_fire || in_fire || out_fire) stall_cycles = 0;
    else stall_cycles++;
  end

  // Mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Drive samples and result backpressure on the falling edge
  always @(negedge clk_i) begin
    // hold a presented sample until its transaction completes
    if (!s_axis_tvalid || in_fire) begin
      if (in_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        in_gap--;
      end else if (rst_ni && pending_samples.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= InTdataW'(pending_samples[0]);
        in_gap = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    if (out_stall > 0) begin
      m_axis_tready <= 1'b0;
      out_stall--;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 99) < 20) out_stall = pick_gap();
    end
  end

  task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
    int seen;
    seen = cfg_writes;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    wait (cfg_writes != seen);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Write all registers; junk above the tick-rate and unlock fields must be dropped
  task automatic set_config(logic [TicksW-1:0] tps, logic [ThreshW-1:0] thr, logic unlock);
    write_reg(REG_TICKS_PER_SECOND, {2'($urandom), tps});
    write_reg(REG_PRESS_THRESHOLD, thr);
    write_reg(REG_ALLOW_UNLOCK, {11'($urandom), unlock});
  endtask

  // Wait until every sample went in and every result came out
  task automatic drain();
    while (pending_samples.size() != 0 || expected_ticks.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic push_sample(logic [SampleW-1:0] smp);
    pending_samples.push_back(smp);
    pushed_count++;
  endtask

  // Queue n ticks at one button level with random content
  task automatic push_level(logic prs, int n);
    repeat (n) begin
      if (prs && thr_q != 0) push_sample(SampleW'($urandom_range(0, int'(thr_q) - 1)));
      else push_sample(SampleW'($urandom_range(int'(thr_q), 4095)));
    end
  endtask

  // Queue one digit: a run of presses, then a half-second release
  task automatic push_digit(int presses);
    int half;
    half = int'(tps_q) / 2;
    for (int p = 0; p < presses; p++) begin
      if ($urandom_range(0, 7) == 0) push_level(1'b1, half + $urandom_range(1, 4));
      else push_level(1'b1, $urandom_range(1, 2));
      // a release shorter than half a second keeps the digit open
      if (p + 1 < presses && half >= 2) push_level(1'b0, $urandom_range(1, half - 1));
    end
    push_level(1'b0, half + $urandom_range(0, 2));
  endtask

  task automatic push_series(int n_digits);
    repeat (n_digits) push_digit(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 9));
    // mostly wipe the store with a five-second release
    if ($urandom_range(0, 9) < 6) push_level(1'b0, int'(tps_q) * 5 + $urandom_range(0, 2));
  endtask

  task automatic run_phase(logic [TicksW-1:0] tps, logic [ThreshW-1:0] thr, logic unlock,
                           int n_items);
    int goal;
    int r;
    calm = ($urandom_range(0, 3) == 0);
    set_config(tps, thr, unlock);
    goal = pushed_count + n_items;
    while (pushed_count < goal) begin
      r = $urandom_range(0, 99);
      if (tps_q > SlowTicks) push_level(1'($urandom_range(0, 1)), $urandom_range(1, 6));
      else if (r < 70) push_series(NumDigits);
      else if (r < 85) push_series($urandom_range(1, 6));
      else repeat ($urandom_range(1, 8)) push_sample(SampleW'($urandom_range(0, 4095)));
    end
    drain();
    calm = 1'b0;
  endtask

  initial begin : watchdog
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // an unused index must leave every register alone
    write_reg(CfgAddrSpare, '1);

    // threshold boundary at the reset configuration
    push_sample(12'd0);
    push_sample(12'd999);
    push_sample(12'd1000);
    push_sample(12'd1001);
    push_sample(12'hFFF);
    drain();

    // one full series latches, a long press, then a five-second wipe
    set_config(10'd2, 12'd2048, 1'b1);
    repeat (NumDigits) begin
      push_level(1'b1, 1);
      push_level(1'b0, 1);
    end
    push_level(1'b1, 3);
    push_level(1'b0, 10);
    drain();

    run_phase(10'd4, 12'd2048, 1'b1, 60);
    run_phase(10'd6, 12'd4095, 1'b1, 30);
    run_phase(10'd5, 12'($urandom_range(1, 4095)), 1'($urandom_range(0, 1)), 30);
    // rates of zero and one are taken literally
    run_phase(10'd0, 12'd2048, 1'b1, 20);
    run_phase(10'd1, 12'd2048, 1'b1, 20);
    run_phase(10'd1023, 12'($urandom_range(1, 4095)), 1'b1, 20);
    // a zero threshold never sees a press
    run_phase(10'd3, 12'd0, 1'b1, 10);
    run_phase(10'($urandom_range(2, 12)), 12'($urandom_range(1, 4095)),
              1'($urandom_range(0, 1)), 30);

    // saturate both timers at the sixty-second limit, 60 ticks at this rate
    set_config(10'd1, 12'd2048, 1'b1);
    push_level(1'b1, 62);
    push_level(1'b0, 62);
    drain();
    // run the series counter around its wrap
    set_config(10'd2, 12'd2048, 1'b1);
    repeat (256) begin
      push_level(1'b1, 1);
      push_level(1'b0, 1);
    end
    drain();
    // the wrapped series latches again, with a code that wraps past 65535
    set_config(10'd4, 12'd2048, 1'b1);
    repeat ($urandom_range(66, 70)) begin
      push_level(1'b1, 1);
      push_level(1'b0, 1);
    end
    push_level(1'b0, 1);
    repeat (NumDigits - 1) push_digit($urandom_range(1, 9));
    push_level(1'b0, 22);
    drain();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/bpsd_pkg.sv
hdl/button_press_series_decoder.sv
hdl/bpsd_checker.sv
tb/tb_button_press_series_decoder.sv
